[rtl/core/fbid_pkg.sv]
// Shared types, widths and codes of the flow beacon interval detector.
`timescale 1ns / 1ps
package fbid_pkg;

   localparam int FLOWS_DEF   = 64;
   localparam int HISTORY_DEF = 10;

   localparam int PROTO_W = 8;
   localparam int IP_W    = 32;
   localparam int PORT_W  = 16;
   localparam int NB_W    = 32;
   localparam int TS_W    = 40;
   localparam int BYTES_W = 48;
   localparam int VERD_W  = 2;
   localparam int CFG_W   = 32;
   localparam int CSR_AW  = 2;
   localparam int MINR_W  = 4;
   localparam int Q_W     = 16;

   localparam int REQ_PROTO_LO = 0;
   localparam int REQ_SRC_LO   = REQ_PROTO_LO + PROTO_W;
   localparam int REQ_DST_LO   = REQ_SRC_LO + IP_W;
   localparam int REQ_PORT_LO  = REQ_DST_LO + IP_W;
   localparam int REQ_BYTES_LO = REQ_PORT_LO + PORT_W;
   localparam int REQ_TS_LO    = REQ_BYTES_LO + NB_W;
   localparam int REQ_W        = REQ_TS_LO + TS_W;
   localparam int RSP_W        = 8;

   localparam logic [VERD_W-1:0] VERDICT_NONE     = 2'd0;
   localparam logic [VERD_W-1:0] VERDICT_ALERT    = 2'd1;
   localparam logic [VERD_W-1:0] VERDICT_FILTERED = 2'd2;
   localparam logic [VERD_W-1:0] VERDICT_FULL     = 2'd3;

   localparam logic [CSR_AW-1:0] CSR_MIN_REPEATS  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_INTERVAL_MIN = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_INTERVAL_MAX = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_MAX_VAR      = 2'd3;

   localparam logic [MINR_W-1:0] MIN_REPEATS_RST  = 4'd5;
   localparam logic [CFG_W-1:0]  INTERVAL_MIN_RST = 32'd1000;
   localparam logic [CFG_W-1:0]  INTERVAL_MAX_RST = 32'd3600000;
   localparam logic [Q_W-1:0]    MAX_VAR_RST      = 16'd51;

   localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
   localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;
   localparam logic [7:0]         MCAST_LO  = 8'd224;
   localparam logic [7:0]         MCAST_HI  = 8'd239;
   localparam logic [IP_W-1:0]    BCAST_IP  = 32'hFFFF_FFFF;
   localparam int                 BYTE_LIMIT = 5000;
   localparam logic [Q_W-1:0]     Q_ONE     = 16'd256;

   localparam int LIMB_W  = 32;
   localparam int MUL_A_W = 96;
   localparam int MUL_B_W = 64;
   localparam int ACC_W   = 128;

   function automatic int idx_w(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic int rec_w(input int h);
      return 2 * IP_W + PORT_W + 1 + idx_w(h + 1) + idx_w(h) + BYTES_W;
   endfunction

   localparam int REC_W_DEF  = rec_w(HISTORY_DEF);
   localparam int HIST_D_DEF = FLOWS_DEF * HISTORY_DEF;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] p;
   } mul_rsp_type;

endpackage

[rtl/core/flow_beacon_interval_detector.sv]
// Top level: event filter, flow table search, update and beacon judgement.
// A filtered event goes straight to the finish step; a tracked event is scanned against the
// flow table and updated, then its kept timestamp intervals are checked when the flow is judged.
// Throughput: one event at a time; the flow table scan (one entry a cycle) and the shared
// multiplier set the rate. A finished result waits in its own register.
// Reset clears control state, valid bits and configuration registers at once; no clearing pass follows.
`timescale 1ns / 1ps
module flow_beacon_interval_detector #(
   parameter int FLOWS   = fbid_pkg::FLOWS_DEF,
   parameter int HISTORY = fbid_pkg::HISTORY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // protocol, src_ip, dst_ip, dst_port, src_bytes, timestamp_ms
   input  logic [fbid_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // verdict, zero fill
   output logic [fbid_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_we,
   input  logic [fbid_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [fbid_pkg::CFG_W-1:0]   csr_wdata
);
   import fbid_pkg::*;

   localparam int FW     = idx_w(FLOWS);
   localparam int CW     = idx_w(HISTORY + 1);
   localparam int HW     = idx_w(HISTORY);
   localparam int HD     = FLOWS * HISTORY;
   localparam int HAW    = idx_w(HD);
   localparam int SW     = TS_W + idx_w(HISTORY);
   localparam int REC_W  = rec_w(HISTORY);
   localparam int BYT_LO = 0;
   localparam int HD_LO  = BYT_LO + BYTES_W;
   localparam int CNT_LO = HD_LO + HW;
   localparam int ALR_LO = CNT_LO + CW;
   localparam int PRT_LO = ALR_LO + 1;
   localparam int DST_LO = PRT_LO + PORT_W;
   localparam int SRC_LO = DST_LO + IP_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SCAN  = 4'd1;
   localparam logic [3:0] ST_UPD   = 4'd2;
   localparam logic [3:0] ST_HRD   = 4'd3;
   localparam logic [3:0] ST_HWT   = 4'd4;
   localparam logic [3:0] ST_HMUL  = 4'd5;
   localparam logic [3:0] ST_MEAN  = 4'd6;
   localparam logic [3:0] ST_SQ    = 4'd7;
   localparam logic [3:0] ST_LHS   = 4'd8;
   localparam logic [3:0] ST_RHS   = 4'd9;
   localparam logic [3:0] ST_ALERT = 4'd10;
   localparam logic [3:0] ST_FIN   = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [MINR_W-1:0]  min_rep_ff, min_rep_in;
   logic [CFG_W-1:0]   imin_ff, imin_in;
   logic [CFG_W-1:0]   imax_ff, imax_in;
   logic [Q_W-1:0]     q_ff, q_in;
   logic [IP_W-1:0]    src_ff, src_in;
   logic [IP_W-1:0]    dst_ff, dst_in;
   logic [PORT_W-1:0]  port_ff, port_in;
   logic [NB_W-1:0]    nb_ff, nb_in;
   logic [TS_W-1:0]    ts_ff, ts_in;
   logic [FW:0]        scan_ff, scan_in;
   logic               rdv_ff, rdv_in;
   logic [FW-1:0]      rdi_ff, rdi_in;
   logic               free_ok_ff, free_ok_in;
   logic [FW-1:0]      free_idx_ff, free_idx_in;
   logic [FW-1:0]      slot_ff, slot_in;
   logic [REC_W-1:0]   rec_ff, rec_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [HW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [TS_W-1:0]    prev_ff, prev_in;
   logic [SW-1:0]      s_ff, s_in;
   logic [ACC_W-1:0]   sq_ff, sq_in;
   logic [ACC_W-1:0]   s2_ff, s2_in;
   logic [ACC_W-1:0]   lhs_ff, lhs_in;
   logic               byte_ok_ff, byte_ok_in;
   logic [VERD_W-1:0]  verdict_ff, verdict_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VERD_W-1:0]  rsp_verdict_ff, rsp_verdict_in;

   logic               flow_rd_en;
   logic [REC_W-1:0]   flow_rd_data;
   logic               flow_rd_valid;
   logic               flow_wr_en;
   logic [REC_W-1:0]   flow_wr_data;
   logic               hist_rd_en;
   logic [HAW-1:0]     hist_rd_addr;
   logic [TS_W-1:0]    hist_rd_data;
   logic               hist_wr_en;
   logic [HAW-1:0]     hist_wr_addr;
   mul_req_type        mul_req;
   mul_rsp_type        mul_rsp;

   logic               req_fire;
   logic [PROTO_W-1:0] req_proto;
   logic [IP_W-1:0]    req_dst;
   logic               filtered;
   logic               hit;
   logic               scan_last;
   logic [BYTES_W-1:0] r_bytes;
   logic [HW-1:0]      r_head;
   logic [CW-1:0]      r_cnt;
   logic               r_alr;
   logic [CW-1:0]      cnt_new;
   logic [HW-1:0]      head_new;
   logic [BYTES_W:0]   bsum;
   logic [BYTES_W-1:0] bytes_new;
   logic [REC_W-1:0]   rec_upd;
   logic [REC_W-1:0]   rec_init;
   logic [REC_W-1:0]   rec_set;
   logic               judge;
   logic [HW+1:0]      oldest_raw;
   logic [HW+1:0]      oldest;
   logic [HAW-1:0]     hbase;
   logic [CW-1:0]      k;
   logic [63:0]        imin_k;
   logic [63:0]        imax_k;
   logic [63:0]        s64;
   logic [TS_W-1:0]    dval;
   logic [2*Q_W-1:0]   q2;
   logic [ACC_W-1:0]   ksq;
   logic [ACC_W-1:0]   lhs_calc;

   fbid_flow_mem #(
      .DEPTH (FLOWS),
      .WIDTH (REC_W),
      .AW    (FW)
   ) u_flow_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (flow_rd_en),
      .rd_addr  (scan_ff[FW-1:0]),
      .rd_data  (flow_rd_data),
      .rd_valid (flow_rd_valid),
      .wr_en    (flow_wr_en),
      .wr_addr  (slot_ff),
      .wr_data  (flow_wr_data)
   );

   fbid_hist_mem #(
      .DEPTH (HD),
      .WIDTH (TS_W),
      .AW    (HAW)
   ) u_hist_mem (
      .clock   (clock),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (ts_ff)
   );

   fbid_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_proto  = req_tdata[REQ_PROTO_LO +: PROTO_W];
   assign req_dst    = req_tdata[REQ_DST_LO +: IP_W];
   assign filtered   = !(req_proto == PROTO_TCP || req_proto == PROTO_UDP)
                       || (req_dst == BCAST_IP)
                       || (req_dst[31:24] >= MCAST_LO && req_dst[31:24] <= MCAST_HI);

   assign hit = rdv_ff && flow_rd_valid
                && flow_rd_data[SRC_LO +: IP_W] == src_ff
                && flow_rd_data[DST_LO +: IP_W] == dst_ff
                && flow_rd_data[PRT_LO +: PORT_W] == port_ff;
   assign scan_last = rdv_ff && (rdi_ff == FW'(FLOWS - 1));

   assign r_bytes  = rec_ff[BYT_LO +: BYTES_W];
   assign r_head   = rec_ff[HD_LO +: HW];
   assign r_cnt    = rec_ff[CNT_LO +: CW];
   assign r_alr    = rec_ff[ALR_LO];
   assign cnt_new  = (r_cnt < CW'(HISTORY)) ? r_cnt + CW'(1) : r_cnt;
   assign head_new = (r_head == HW'(HISTORY - 1)) ? '0 : r_head + HW'(1);
   assign bsum     = {1'b0, r_bytes} + (BYTES_W + 1)'(nb_ff);
   assign bytes_new = bsum[BYTES_W] ? {BYTES_W{1'b1}} : bsum[BYTES_W-1:0];
   assign rec_upd  = {src_ff, dst_ff, port_ff, r_alr, cnt_new, head_new, bytes_new};
   assign rec_init = {src_ff, dst_ff, port_ff, 1'b0, {CW{1'b0}}, {HW{1'b0}},
                      {BYTES_W{1'b0}}};
   assign judge    = !r_alr && (8'(cnt_new) >= 8'(min_rep_ff)) && (cnt_new >= CW'(2));
   assign oldest_raw = (HW + 2)'(head_new) + (HW + 2)'(HISTORY) - (HW + 2)'(cnt_new);
   assign oldest   = (oldest_raw >= (HW + 2)'(HISTORY)) ?
                     oldest_raw - (HW + 2)'(HISTORY) : oldest_raw;
   assign hbase    = HAW'(slot_ff) * HAW'(HISTORY);

   assign k        = n_ff - CW'(1);
   assign imin_k   = 64'(imin_ff) * 64'(k);
   assign imax_k   = 64'(imax_ff) * 64'(k);
   assign s64      = 64'(s_ff);
   assign dval     = hist_rd_data - prev_ff;
   assign q2       = {{Q_W{1'b0}}, q_ff} * {{Q_W{1'b0}}, q_ff};
   assign ksq      = sq_ff * ACC_W'(k);
   assign lhs_calc = (ksq - s2_ff) << 16;

   always_comb begin
      rec_set         = rec_ff;
      rec_set[ALR_LO] = 1'b1;
   end

   always_comb begin
      state_in       = state_ff;
      min_rep_in     = min_rep_ff;
      imin_in        = imin_ff;
      imax_in        = imax_ff;
      q_in           = q_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      port_in        = port_ff;
      nb_in          = nb_ff;
      ts_in          = ts_ff;
      scan_in        = scan_ff;
      rdv_in         = 1'b0;
      rdi_in         = rdi_ff;
      free_ok_in     = free_ok_ff;
      free_idx_in    = free_idx_ff;
      slot_in        = slot_ff;
      rec_in         = rec_ff;
      n_in           = n_ff;
      ptr_in         = ptr_ff;
      idx_in         = idx_ff;
      prev_in        = prev_ff;
      s_in           = s_ff;
      sq_in          = sq_ff;
      s2_in          = s2_ff;
      lhs_in         = lhs_ff;
      byte_ok_in     = byte_ok_ff;
      verdict_in     = verdict_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_verdict_in = rsp_verdict_ff;
      flow_rd_en     = 1'b0;
      flow_wr_en     = 1'b0;
      flow_wr_data   = rec_upd;
      hist_rd_en     = 1'b0;
      hist_rd_addr   = hbase + HAW'(ptr_ff);
      hist_wr_en     = 1'b0;
      hist_wr_addr   = hbase + HAW'(r_head);
      mul_req.start  = 1'b0;
      mul_req.a      = MUL_A_W'(dval);
      mul_req.b      = MUL_B_W'(dval);

      if (csr_we) begin
         case (csr_addr)
            CSR_MIN_REPEATS: begin
               min_rep_in = csr_wdata[MINR_W-1:0];
            end
            CSR_INTERVAL_MIN: begin
               imin_in = csr_wdata;
            end
            CSR_INTERVAL_MAX: begin
               imax_in = csr_wdata;
            end
            CSR_MAX_VAR: begin
               q_in = csr_wdata[Q_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               src_in     = req_tdata[REQ_SRC_LO +: IP_W];
               dst_in     = req_dst;
               port_in    = req_tdata[REQ_PORT_LO +: PORT_W];
               nb_in      = req_tdata[REQ_BYTES_LO +: NB_W];
               ts_in      = req_tdata[REQ_TS_LO +: TS_W];
               scan_in    = '0;
               free_ok_in = 1'b0;
               if (filtered) begin
                  verdict_in = VERDICT_FILTERED;
                  state_in   = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff < (FW + 1)'(FLOWS)) begin
               flow_rd_en = 1'b1;
               scan_in    = scan_ff + (FW + 1)'(1);
               rdv_in     = 1'b1;
               rdi_in     = scan_ff[FW-1:0];
            end
            if (rdv_ff && !flow_rd_valid && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = rdi_ff;
            end
            if (hit) begin
               slot_in  = rdi_ff;
               rec_in   = flow_rd_data;
               state_in = ST_UPD;
            end else if (scan_last) begin
               if (free_ok_ff || !flow_rd_valid) begin
                  slot_in  = free_ok_ff ? free_idx_ff : rdi_ff;
                  rec_in   = rec_init;
                  state_in = ST_UPD;
               end else begin
                  verdict_in = VERDICT_FULL;
                  state_in   = ST_FIN;
               end
            end
         end
         ST_UPD: begin
            flow_wr_en = 1'b1;
            hist_wr_en = 1'b1;
            rec_in     = rec_upd;
            n_in       = cnt_new;
            ptr_in     = HW'(oldest);
            idx_in     = '0;
            s_in       = '0;
            sq_in      = '0;
            byte_ok_in = bytes_new < (BYTES_W'(cnt_new) * BYTES_W'(BYTE_LIMIT));
            verdict_in = VERDICT_NONE;
            state_in   = judge ? ST_HRD : ST_FIN;
         end
         ST_HRD: begin
            hist_rd_en = 1'b1;
            ptr_in     = (ptr_ff == HW'(HISTORY - 1)) ? '0 : ptr_ff + HW'(1);
            state_in   = ST_HWT;
         end
         ST_HWT: begin
            idx_in  = idx_ff + CW'(1);
            prev_in = hist_rd_data;
            if (idx_ff == '0) begin
               state_in = ST_HRD;
            end else begin
               s_in          = s_ff + SW'(dval);
               mul_req.start = 1'b1;
               state_in      = ST_HMUL;
            end
         end
         ST_HMUL: begin
            if (mul_rsp.done) begin
               sq_in    = sq_ff + mul_rsp.p;
               state_in = (idx_ff == n_ff) ? ST_MEAN : ST_HRD;
            end
         end
         ST_MEAN: begin
            mul_req.a = MUL_A_W'(s_ff);
            mul_req.b = MUL_B_W'(s_ff);
            if (s64 < imin_k || s64 > imax_k) begin
               state_in = ST_FIN;
            end else if (s_ff == '0) begin
               state_in = (q_ff >= Q_ONE && byte_ok_ff) ? ST_ALERT : ST_FIN;
            end else begin
               mul_req.start = 1'b1;
               state_in      = ST_SQ;
            end
         end
         ST_SQ: begin
            if (mul_rsp.done) begin
               s2_in    = mul_rsp.p;
               state_in = ST_LHS;
            end
         end
         ST_LHS: begin
            lhs_in        = lhs_calc;
            mul_req.a     = s2_ff[MUL_A_W-1:0];
            mul_req.b     = MUL_B_W'(q2);
            mul_req.start = 1'b1;
            state_in      = ST_RHS;
         end
         ST_RHS: begin
            if (mul_rsp.done) begin
               state_in = (lhs_ff <= mul_rsp.p && byte_ok_ff) ? ST_ALERT : ST_FIN;
            end
         end
         ST_ALERT: begin
            flow_wr_en   = 1'b1;
            flow_wr_data = rec_set;
            verdict_in   = VERDICT_ALERT;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         min_rep_ff   <= MIN_REPEATS_RST;
         imin_ff      <= INTERVAL_MIN_RST;
         imax_ff      <= INTERVAL_MAX_RST;
         q_ff         <= MAX_VAR_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= rdv_in;
         min_rep_ff   <= min_rep_in;
         imin_ff      <= imin_in;
         imax_ff      <= imax_in;
         q_ff         <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      port_ff        <= port_in;
      nb_ff          <= nb_in;
      ts_ff          <= ts_in;
      scan_ff        <= scan_in;
      rdi_ff         <= rdi_in;
      free_ok_ff     <= free_ok_in;
      free_idx_ff    <= free_idx_in;
      slot_ff        <= slot_in;
      rec_ff         <= rec_in;
      n_ff           <= n_in;
      ptr_ff         <= ptr_in;
      idx_ff         <= idx_in;
      prev_ff        <= prev_in;
      s_ff           <= s_in;
      sq_ff          <= sq_in;
      s2_ff          <= s2_in;
      lhs_ff         <= lhs_in;
      byte_ok_ff     <= byte_ok_in;
      verdict_ff     <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - VERD_W){1'b0}}, rsp_verdict_ff};

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside the finish step");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("accepted event left no work");
   a_alert_judged: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALERT) |-> (!r_alr && n_ff >= CW'(2)))
      else $error("alert on flow that was not eligible");
   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_HMUL || state_ff == ST_SQ || state_ff == ST_RHS))
      else $error("product arrived with nobody waiting");

endmodule

[rtl/core/fbid_flow_mem.sv]
// Flow table memory with per-entry valid bits.
`timescale 1ns / 1ps
module fbid_flow_mem #(
   parameter int DEPTH = fbid_pkg::FLOWS_DEF,
   parameter int WIDTH = fbid_pkg::REC_W_DEF,
   parameter int AW    = fbid_pkg::idx_w(fbid_pkg::FLOWS_DEF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   output logic             rd_valid,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);
   import fbid_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

[rtl/core/fbid_hist_mem.sv]
// Timestamp history memory, one row of slots per flow.
`timescale 1ns / 1ps
module fbid_hist_mem #(
   parameter int DEPTH = fbid_pkg::HIST_D_DEF,
   parameter int WIDTH = fbid_pkg::TS_W,
   parameter int AW    = fbid_pkg::idx_w(fbid_pkg::HIST_D_DEF)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);
   import fbid_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/fbid_mul.sv]
// Multi-cycle wide multiplier built on one 32x32 partial product unit.
`timescale 1ns / 1ps
module fbid_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  fbid_pkg::mul_req_type mul_req,
   output fbid_pkg::mul_rsp_type mul_rsp
);
   import fbid_pkg::*;

   logic [MUL_A_W-1:0]  a_ff, a_in;
   logic [MUL_B_W-1:0]  b_ff, b_in;
   logic [1:0]          ia_ff, ia_in;
   logic                ib_ff, ib_in;
   logic                run_ff, run_in;
   logic [2*LIMB_W-1:0] pp_ff, pp_in;
   logic [1:0]          sh_ff, sh_in;
   logic                ppv_ff, ppv_in;
   logic                last_ff, last_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                done_ff, done_in;
   logic [LIMB_W-1:0]   a_limb;
   logic [LIMB_W-1:0]   b_limb;
   logic                last_step;

   always_comb begin
      case (ia_ff)
         2'd0: begin
            a_limb = a_ff[0 +: LIMB_W];
         end
         2'd1: begin
            a_limb = a_ff[LIMB_W +: LIMB_W];
         end
         default: begin
            a_limb = a_ff[2*LIMB_W +: LIMB_W];
         end
      endcase
      b_limb    = ib_ff ? b_ff[LIMB_W +: LIMB_W] : b_ff[0 +: LIMB_W];
      last_step = (ia_ff == 2'd2) && ib_ff;

      a_in    = a_ff;
      b_in    = b_ff;
      ia_in   = ia_ff;
      ib_in   = ib_ff;
      run_in  = run_ff;
      acc_in  = acc_ff;
      pp_in   = {{LIMB_W{1'b0}}, a_limb} * {{LIMB_W{1'b0}}, b_limb};
      sh_in   = ia_ff + {1'b0, ib_ff};
      ppv_in  = run_ff;
      last_in = run_ff && last_step;
      done_in = ppv_ff && last_ff;

      if (mul_req.start) begin
         a_in   = mul_req.a;
         b_in   = mul_req.b;
         ia_in  = 2'd0;
         ib_in  = 1'b0;
         run_in = 1'b1;
         acc_in = '0;
      end else if (run_ff) begin
         if (last_step) begin
            run_in = 1'b0;
         end
         if (ia_ff == 2'd2) begin
            ia_in = 2'd0;
            ib_in = 1'b1;
         end else begin
            ia_in = ia_ff + 2'd1;
         end
      end
      if (ppv_ff) begin
         acc_in = acc_ff + ({{(ACC_W-2*LIMB_W){1'b0}}, pp_ff} << {sh_ff, 5'd0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         ppv_ff  <= 1'b0;
         last_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         ppv_ff  <= ppv_in;
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      ia_ff  <= ia_in;
      ib_ff  <= ib_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.p    = acc_ff;

   a_start_run: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |=> run_ff)
      else $error("multiplier did not start");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> (!run_ff && !ppv_ff))
      else $error("multiplier started while busy");
   a_done_stopped: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("multiplier done while still running");

endmodule
